>>> src/assert_macros.svh
// Assertion macros used by the remapper back end RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// property checked every clock outside reset
`define RORM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// consequent must hold in the cycle after the antecedent
`define RORM_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define RORM_ASSERT(label, prop, msg)
`define RORM_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> src/rorm_pkg.sv
// Types and constants shared by the radar object id remapper.
package rorm_pkg;

	localparam int TIME_W     = 52;
	localparam int WIN_W      = 24;
	localparam int STATE_W    = 3;
	localparam int LID_W      = 8;
	localparam int GID_W      = 16;
	localparam int CFG_ADDR_W = 4;
	localparam int CFG_DATA_W = 32;
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam logic [WIN_W-1:0]   WINDOW_RST    = 24'd70000;
	localparam logic [WIN_W-1:0]   DELAY_RST     = 24'd0;
	localparam logic [STATE_W-1:0] NEW_STATE_RST = 3'd1;

	typedef enum logic [1:0] {
		REG_WINDOW    = 2'd0,
		REG_DELAY     = 2'd1,
		REG_NEW_STATE = 2'd2
	} rorm_reg_t;

	typedef enum logic {
		BK_IDLE,
		BK_LOOK
	} rorm_bk_state_t;

	typedef struct packed {
		logic [WIN_W-1:0]   window_us;
		logic [WIN_W-1:0]   delay_us;
		logic [STATE_W-1:0] new_state_code;
	} rorm_cfg_t;

	// one classified object waiting for the map stage
	typedef struct packed {
		logic              kept;
		logic              is_new;
		logic [LID_W-1:0]  idx;
		logic [TIME_W-1:0] corrected;
	} rorm_item_t;

endpackage

>>> src/rorm_cfg.sv
// APB register file: window, delay and new-state code.
module rorm_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [rorm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [rorm_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [rorm_pkg::CFG_DATA_W-1:0] prdata,
	output logic                           pready,
	output rorm_pkg::rorm_cfg_t            cfg
);
	import rorm_pkg::*;

	rorm_cfg_t cfg_q;
	rorm_reg_t reg_sel;
	logic      wr_en;

	assign reg_sel = rorm_reg_t'(paddr[3:2]);
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.window_us      <= WINDOW_RST;
			cfg_q.delay_us       <= DELAY_RST;
			cfg_q.new_state_code <= NEW_STATE_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_WINDOW:    cfg_q.window_us      <= pwdata[WIN_W-1:0];
				REG_DELAY:     cfg_q.delay_us       <= pwdata[WIN_W-1:0];
				REG_NEW_STATE: cfg_q.new_state_code <= pwdata[STATE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_sel)
			REG_WINDOW:    prdata = {(CFG_DATA_W-WIN_W)'(0), cfg_q.window_us};
			REG_DELAY:     prdata = {(CFG_DATA_W-WIN_W)'(0), cfg_q.delay_us};
			REG_NEW_STATE: prdata = {(CFG_DATA_W-STATE_W)'(0), cfg_q.new_state_code};
			default:       prdata = '0;
		endcase
	end

endmodule

>>> src/rorm_front.sv
// Front end: window test, delay correction and map index of each object.
module rorm_front #(
	parameter int unsigned LOCAL_IDS = 256
) (
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [rorm_pkg::TIME_W-1:0]  frame_time_us,
	input  logic [rorm_pkg::TIME_W-1:0]  object_time_us,
	input  logic [rorm_pkg::LID_W-1:0]   local_id,
	input  logic [rorm_pkg::STATE_W-1:0] meas_state,
	input  rorm_pkg::rorm_cfg_t         cfg,
	input  logic                        q_full,
	output logic                        q_push,
	output rorm_pkg::rorm_item_t        q_item
);
	import rorm_pkg::*;

	localparam int unsigned MOD_SH    = 16;
	// rounded-up reciprocal of LOCAL_IDS; exact for every 8-bit id below 256 entries
	localparam int unsigned MOD_RECIP = (LOCAL_IDS < 256) ?
		(((1 << MOD_SH) + LOCAL_IDS - 1) / LOCAL_IDS) : 0;

	logic [TIME_W:0]         obj_diff;
	logic [TIME_W:0]         cor_diff;
	logic [WIN_W:0]          span;
	logic [LID_W-1:0]        rem;
	logic [LID_W+MOD_SH-1:0] mod_prod;
	logic [LID_W-1:0]        mod_quot;

	// object lies in [frame, frame + window - 1): diff + 1 < window
	assign obj_diff = {1'b0, object_time_us} - {1'b0, frame_time_us};
	assign span     = {1'b0, obj_diff[WIN_W-1:0]} + (WIN_W+1)'(1);
	assign cor_diff = {1'b0, frame_time_us} - {(TIME_W-WIN_W+1)'(0), cfg.delay_us};

	// local_id modulo LOCAL_IDS by reciprocal multiplication
	assign mod_prod = (LID_W+MOD_SH)'(local_id) * (LID_W+MOD_SH)'(MOD_RECIP);
	assign mod_quot = mod_prod[LID_W+MOD_SH-1:MOD_SH];
	assign rem      = (LOCAL_IDS < 256) ? (local_id - LID_W'(mod_quot * LOCAL_IDS)) : local_id;

	always_comb begin
		q_item.kept      = !obj_diff[TIME_W] && (obj_diff[TIME_W-1:WIN_W] == '0)
			&& (span < {1'b0, cfg.window_us});
		q_item.is_new    = (meas_state == cfg.new_state_code);
		q_item.idx       = rem;
		q_item.corrected = cor_diff[TIME_W] ? '0 : cor_diff[TIME_W-1:0];
	end

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

endmodule

>>> src/rorm_queue.sv
// Short queue of classified objects between front and back end.
module rorm_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  rorm_pkg::rorm_item_t push_item,
	output logic                 full,
	input  logic                 pop,
	output logic                 not_empty,
	output rorm_pkg::rorm_item_t head
);
	import rorm_pkg::*;

	rorm_item_t              entry_q [QUEUE_DEPTH];
	logic [QUEUE_PTR_W-1:0]  wr_ptr_q;
	logic [QUEUE_PTR_W-1:0]  rd_ptr_q;
	logic [QUEUE_CNT_W-1:0]  count_q;

	assign full      = (count_q == QUEUE_CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QUEUE_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QUEUE_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + QUEUE_CNT_W'(1);
				2'b01:   count_q <= count_q - QUEUE_CNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule

>>> src/rorm_back.sv
// Back end: id map lookup and update, id counter, output register.
`include "assert_macros.svh"

module rorm_back #(
	parameter int unsigned LOCAL_IDS = 256,
	parameter int unsigned ID_LIMIT  = 65535
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_not_empty,
	input  rorm_pkg::rorm_item_t        q_head,
	output logic                        q_pop,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        kept,
	output logic [rorm_pkg::GID_W-1:0]  global_id,
	output logic [rorm_pkg::TIME_W-1:0] corrected_frame_time_us
);
	import rorm_pkg::*;

	localparam int unsigned MAP_DEPTH = (LOCAL_IDS < 256) ? LOCAL_IDS : 256;
	localparam int          IDX_W     = $clog2(MAP_DEPTH);

	rorm_bk_state_t state_q, state_d;

	logic [GID_W-1:0]     map_mem [MAP_DEPTH];
	logic [GID_W-1:0]     rd_data_q;
	logic [MAP_DEPTH-1:0] map_valid_q;
	logic [GID_W-1:0]     cnt_q;
	rorm_item_t           item_s1;

	logic [IDX_W-1:0]  head_idx;
	logic [IDX_W-1:0]  cur_idx;
	logic [GID_W:0]    cnt_inc;
	logic [GID_W-1:0]  cnt_next;
	logic              hit;
	logic              need_new;
	logic              load_out;
	logic              out_valid_q;
	logic              kept_q;
	logic [GID_W-1:0]  gid_q;
	logic [TIME_W-1:0] corrected_q;
	logic [GID_W-1:0]  gid_d;

	assign head_idx = q_head.idx[IDX_W-1:0];
	assign cur_idx  = item_s1.idx[IDX_W-1:0];

	// counter steps before use and wraps back to one at the limit
	assign cnt_inc  = {1'b0, cnt_q} + (GID_W+1)'(1);
	assign cnt_next = (cnt_inc >= (GID_W+1)'(ID_LIMIT)) ? GID_W'(1) : cnt_inc[GID_W-1:0];

	assign hit      = map_valid_q[cur_idx] && !item_s1.is_new;
	assign need_new = item_s1.kept && !hit;

	always_comb begin
		if (!item_s1.kept) begin
			gid_d = '0;
		end else if (hit) begin
			gid_d = rd_data_q;
		end else begin
			gid_d = cnt_next;
		end
	end

	always_comb begin
		state_d  = state_q;
		q_pop    = 1'b0;
		load_out = 1'b0;
		case (state_q)
			BK_IDLE: begin
				if (q_not_empty) begin
					q_pop   = 1'b1;
					state_d = BK_LOOK;
				end
			end
			BK_LOOK: begin
				if (!out_valid_q || !out_stall) begin
					load_out = 1'b1;
					state_d  = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// map read is issued on pop, the registered result is used in BK_LOOK
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_data_q <= map_mem[head_idx];
		end
	end

	always_ff @(posedge clk) begin
		if (load_out && need_new) begin
			map_mem[cur_idx] <= cnt_next;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_s1 <= q_head;
		end
		if (load_out) begin
			kept_q      <= item_s1.kept;
			gid_q       <= gid_d;
			corrected_q <= item_s1.corrected;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_valid_q <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out && need_new) begin
				map_valid_q[cur_idx] <= 1'b1;
				cnt_q                <= cnt_next;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid               = out_valid_q;
	assign kept                    = kept_q;
	assign global_id               = gid_q;
	assign corrected_frame_time_us = corrected_q;

	`RORM_ASSERT(a_cnt_range, cnt_q < GID_W'(ID_LIMIT), "id counter reached the limit")
	`RORM_ASSERT(a_gid_kept, !out_valid_q || (kept_q == (gid_q != '0)), "id zero iff skipped")
	`RORM_ASSERT_NEXT(a_new_id, load_out && need_new, gid_q == cnt_q, "new id not from counter")

endmodule

>>> src/radar_object_id_remapper.sv
// Radar object id remapper top level: registers, front end, queue and map back end.
// Each object report is checked against the window after its frame time, tagged
// with the frame time minus the configured delay, and, if kept, given a global id
// from the per-local-id map or, on a miss or a new-object state, from a counter
// that runs 1..ID_LIMIT-1. The front end pushes one report a cycle into the
// two-entry queue unless it is full; the back end pops a new object only once the
// last one is loaded into the output register, as the map read registered on pop
// in BK_IDLE is followed by the map update in BK_LOOK. A report passes the queue,
// BK_IDLE and BK_LOOK; the output register frees the back end while a result waits.
module radar_object_id_remapper #(
	parameter int unsigned LOCAL_IDS = 256,
	parameter int unsigned ID_LIMIT  = 65535
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [rorm_pkg::CFG_ADDR_W-1:0] paddr,
	input  logic [rorm_pkg::CFG_DATA_W-1:0] pwdata,
	output logic [rorm_pkg::CFG_DATA_W-1:0] prdata,
	output logic                            pready,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [rorm_pkg::TIME_W-1:0]     frame_time_us,
	input  logic [rorm_pkg::TIME_W-1:0]     object_time_us,
	input  logic [rorm_pkg::LID_W-1:0]      local_id,
	input  logic [rorm_pkg::STATE_W-1:0]    meas_state,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic                            kept,
	output logic [rorm_pkg::GID_W-1:0]      global_id,
	output logic [rorm_pkg::TIME_W-1:0]     corrected_frame_time_us
);
	import rorm_pkg::*;

	rorm_cfg_t  cfg;
	rorm_item_t push_item;
	rorm_item_t head;
	logic       push;
	logic       full;
	logic       pop;
	logic       not_empty;

	rorm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rorm_front #(
		.LOCAL_IDS (LOCAL_IDS)
	) u_front (
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.frame_time_us  (frame_time_us),
		.object_time_us (object_time_us),
		.local_id       (local_id),
		.meas_state     (meas_state),
		.cfg            (cfg),
		.q_full         (full),
		.q_push         (push),
		.q_item         (push_item)
	);

	rorm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (full),
		.pop       (pop),
		.not_empty (not_empty),
		.head      (head)
	);

	rorm_back #(
		.LOCAL_IDS (LOCAL_IDS),
		.ID_LIMIT  (ID_LIMIT)
	) u_back (
		.clk                     (clk),
		.arst_n                  (arst_n),
		.q_not_empty             (not_empty),
		.q_head                  (head),
		.q_pop                   (pop),
		.out_valid               (out_valid),
		.out_stall               (out_stall),
		.kept                    (kept),
		.global_id               (global_id),
		.corrected_frame_time_us (corrected_frame_time_us)
	);

endmodule

>>> tb/sv/tb.sv
// Self-checking testbench for the radar object id remapper: stimulus, id prediction and checks.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rorm_pkg::*;

	localparam int unsigned LOCAL_IDS   = 256;
	localparam int unsigned ID_LIMIT    = 65535;
	localparam int unsigned CYCLE_LIMIT = 4000000;
	localparam logic [TIME_W-1:0] T_MAX = '1;
	localparam logic [WIN_W-1:0]  W_MAX = '1;

	typedef struct packed {
		logic [TIME_W-1:0]  frame;
		logic [TIME_W-1:0]  obj;
		logic [LID_W-1:0]   lid;
		logic [STATE_W-1:0] state;
	} report_t;

	typedef struct packed {
		logic              kept;
		logic [GID_W-1:0]  gid;
		logic [TIME_W-1:0] corr;
	} remap_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  psel = 1'b0;
	logic                  penable = 1'b0;
	logic                  pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [CFG_DATA_W-1:0] pwdata = '0;
	logic [CFG_DATA_W-1:0] prdata;
	logic                  pready;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [TIME_W-1:0]     frame_time_us = '0;
	logic [TIME_W-1:0]     object_time_us = '0;
	logic [LID_W-1:0]      local_id = '0;
	logic [STATE_W-1:0]    meas_state = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic                  kept;
	logic [GID_W-1:0]      global_id;
	logic [TIME_W-1:0]     corrected_frame_time_us;

	radar_object_id_remapper #(
		.LOCAL_IDS(LOCAL_IDS),
		.ID_LIMIT (ID_LIMIT)
	) dut (.*);

	always #2 clk = ~clk;

	// shadow of the block's registers and id state
	logic [WIN_W-1:0]   win_cfg = WINDOW_RST;
	logic [WIN_W-1:0]   dly_cfg = DELAY_RST;
	logic [STATE_W-1:0] new_cfg = NEW_STATE_RST;
	logic [GID_W-1:0]   gid_table [LOCAL_IDS];
	bit                 slot_used [LOCAL_IDS];
	logic [GID_W-1:0]   gid_count = '0;

	report_t report_q[$];
	remap_t  remap_q[$];

	int  n_errors, n_checked, n_kept, n_wraps, n_settings, cycle_cnt;
	bit  idle_on;
	int  stall_mode;

	function automatic remap_t predict_remap(report_t r);
		remap_t res;
		logic [TIME_W+1:0] lim;
		int unsigned idx;
		res = '0;
		idx = r.lid % LOCAL_IDS;
		lim = {2'b00, r.frame} + {(TIME_W-WIN_W+2)'(0), win_cfg};
		// obj < frame + window - 1, written without underflow
		res.kept = (r.obj >= r.frame) && (({2'b00, r.obj} + 54'd1) < lim);
		if (res.kept) begin
			n_kept++;
			if (slot_used[idx] && r.state != new_cfg) begin
				res.gid = gid_table[idx];
			end else begin
				if (gid_count >= GID_W'(ID_LIMIT - 1)) begin
					gid_count = GID_W'(1);
					n_wraps++;
				end else begin
					gid_count = gid_count + GID_W'(1);
				end
				res.gid = gid_count;
				gid_table[idx] = gid_count;
				slot_used[idx] = 1'b1;
			end
		end
		res.corr = (r.frame >= {(TIME_W-WIN_W)'(0), dly_cfg}) ?
			r.frame - {(TIME_W-WIN_W)'(0), dly_cfg} : '0;
		return res;
	endfunction

	function automatic logic [TIME_W-1:0] pick_time();
		logic [63:0] w;
		w = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: return TIME_W'($urandom_range(0, 1000));
			1: return T_MAX - TIME_W'($urandom_range(0, 1000));
			default: return w[TIME_W-1:0];
		endcase
	endfunction

	// mostly objects placed on or near the window edges, some noise
	function automatic report_t make_report();
		report_t r;
		logic [TIME_W-1:0] off;
		int unsigned pick;
		r.frame = pick_time();
		pick = $urandom_range(0, 9);
		if (pick < 7) begin
			case ($urandom_range(0, 3))
				0: off = '0;
				1: off = {(TIME_W-WIN_W)'(0), win_cfg} - TIME_W'(2);
				2: off = {(TIME_W-WIN_W)'(0), win_cfg} - TIME_W'(1);
				default: off = TIME_W'($urandom_range(0, win_cfg));
			endcase
			r.obj = r.frame + off;
		end else if (pick == 7) begin
			r.obj = r.frame - TIME_W'($urandom_range(1, 3));
		end else begin
			r.obj = pick_time();
		end
		// a small hot set of ids so that map hits are common
		r.lid = ($urandom_range(0, 9) < 7) ? LID_W'($urandom_range(0, 15)) :
			LID_W'($urandom_range(0, 255));
		r.state = STATE_W'($urandom_range(0, 7));
		return r;
	endfunction

	task automatic push_report(logic [TIME_W-1:0] frame, logic [TIME_W-1:0] obj,
			logic [LID_W-1:0] lid, logic [STATE_W-1:0] state);
		report_q.insert(report_q.size(), report_t'{frame, obj, lid, state});
	endtask

	// wait until every report is out and checked, then let the pipeline settle
	task automatic drain();
		while (report_q.size() != 0 || remap_q.size() != 0 || in_valid)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic reg_write(rorm_reg_t r, logic [CFG_DATA_W-1:0] v);
		logic [CFG_DATA_W-1:0] mask;
		case (r)
			REG_WINDOW: begin
				mask = CFG_DATA_W'((1 << WIN_W) - 1);
				win_cfg = v[WIN_W-1:0];
			end
			REG_DELAY: begin
				mask = CFG_DATA_W'((1 << WIN_W) - 1);
				dly_cfg = v[WIN_W-1:0];
			end
			default: begin
				mask = CFG_DATA_W'((1 << STATE_W) - 1);
				new_cfg = v[STATE_W-1:0];
			end
		endcase
		@(posedge clk);
		psel    <= 1'b1;
		pwrite  <= 1'b1;
		paddr   <= {r, 2'b00};
		pwdata  <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		// read back
		@(posedge clk);
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(negedge clk);
		if ((prdata & mask) !== (v & mask)) begin
			$error("register %s readback: expected %0h, got %0h", r.name(), v & mask, prdata);
			n_errors++;
		end
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		n_settings++;
	endtask

	// sender: bursts of transfers separated by random gaps when idle_on is set
	int burst_left, gap_left;
	report_t nxt_report;

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			remap_q.insert(remap_q.size(), predict_remap('{frame_time_us, object_time_us,
				local_id, meas_state}));
		if (!in_valid || !in_stall) begin
			if (gap_left > 0) begin
				in_valid <= 1'b0;
				gap_left--;
			end else if (arst_n && report_q.size() != 0) begin
				nxt_report = report_q.pop_front();
				frame_time_us  <= nxt_report.frame;
				object_time_us <= nxt_report.obj;
				local_id       <= nxt_report.lid;
				meas_state     <= nxt_report.state;
				in_valid       <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 12);
					gap_left = idle_on ? $urandom_range(1, 4) : 0;
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver: eight-bit stall pattern shifted out and reloaded when spent, plus result checks
	logic [7:0] stall_pat = '0;
	int         stall_cnt;
	remap_t     want;

	always @(posedge clk) begin
		if (stall_cnt == 0) begin
			stall_pat = (stall_mode == 2) ? 8'($urandom | $urandom) : 8'($urandom & $urandom);
			stall_cnt = 7;
		end else begin
			stall_pat = stall_pat >> 1;
			stall_cnt--;
		end
		out_stall <= (stall_mode != 0) && stall_pat[0];

		if (arst_n && out_valid && !out_stall) begin
			if (remap_q.size() == 0) begin
				$error("result transfer with no report outstanding");
				n_errors++;
			end else begin
				want = remap_q.pop_front();
				n_checked++;
				if (kept !== want.kept) begin
					$error("kept: expected %0d, got %0d", want.kept, kept);
					n_errors++;
				end
				if (global_id !== want.gid) begin
					$error("global_id: expected %0d, got %0d", want.gid, global_id);
					n_errors++;
				end
				if (corrected_frame_time_us !== want.corr) begin
					$error("corrected_frame_time_us: expected %0h, got %0h", want.corr,
						corrected_frame_time_us);
					n_errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("radar_object_id_remapper regression: fail");
			$finish;
		end
	end

	initial begin
		idle_on = 1'b1;
		stall_mode = 1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings: window 70000, no delay, new code 1
		push_report(0, 0, 0, 0);
		push_report(0, 0, 0, 0);
		push_report(5, 5, 0, 1);
		push_report(T_MAX, T_MAX, 8'hFF, 7);
		push_report(100, 99, 8'hFF, 0);
		push_report(100, 100 + WINDOW_RST - 2, 8'hFF, 2);
		push_report(100, 100 + WINDOW_RST - 1, 17, 0);
		push_report(T_MAX, 0, 17, 0);
		push_report(0, T_MAX, 17, 0);
		drain();

		// narrowest useful window, largest delay, highest new code
		reg_write(REG_WINDOW, 2);
		reg_write(REG_DELAY, W_MAX);
		reg_write(REG_NEW_STATE, 7);
		push_report(W_MAX - 1, W_MAX - 1, 0, 0);
		push_report(W_MAX, W_MAX, 0, 7);
		push_report(W_MAX + 1, W_MAX + 2, 3, 0);
		push_report(T_MAX, T_MAX, 3, 0);
		push_report(0, 0, 8'hFF, 7);
		drain();

		// windows of zero and one keep nothing
		reg_write(REG_WINDOW, 0);
		push_report(50, 50, 1, 0);
		push_report(T_MAX, T_MAX, 1, 0);
		drain();
		reg_write(REG_WINDOW, 1);
		push_report(50, 50, 1, 0);
		push_report(0, 0, 2, 0);
		drain();

		for (int p = 0; p < 6; p++) begin
			case ($urandom_range(0, 4))
				0: reg_write(REG_WINDOW, 1);
				1: reg_write(REG_WINDOW, 2);
				2: reg_write(REG_WINDOW, W_MAX);
				3: reg_write(REG_WINDOW, WINDOW_RST);
				default: reg_write(REG_WINDOW, $urandom_range(3, 5000));
			endcase
			case ($urandom_range(0, 2))
				0: reg_write(REG_DELAY, 0);
				1: reg_write(REG_DELAY, W_MAX);
				default: reg_write(REG_DELAY, $urandom_range(1, W_MAX));
			endcase
			reg_write(REG_NEW_STATE, $urandom_range(0, 7));
			idle_on = (p != 0);
			stall_mode = (p == 0) ? 0 : $urandom_range(0, 2);
			repeat (110) report_q.insert(report_q.size(), make_report());
			drain();
		end

		reg_write(REG_NEW_STATE, 0);
		idle_on = 1'b1;
		stall_mode = 2;
		repeat (60) report_q.insert(report_q.size(), make_report());
		drain();

		$display("run covered %0d result transfers, %0d kept objects, %0d id counter wraps",
			n_checked, n_kept, n_wraps);
		$display("over %0d register writes with read-back", n_settings);
		if (n_errors == 0)
			$display("radar_object_id_remapper regression: pass");
		else
			$display("radar_object_id_remapper regression: fail");
		$finish;
	end

endmodule

>>> files.f
+incdir+src
src/rorm_pkg.sv
src/rorm_cfg.sv
src/rorm_front.sv
src/rorm_queue.sv
src/rorm_back.sv
src/radar_object_id_remapper.sv
tb/sv/tb.sv
